// ----- src/timed_handle_cooldown_table_assert.svh -----
// ----------------------------------------------------------------------------
// Timed handle cooldown table - assertion macros
// Shared concurrent assertion forms used by the table RTL.
// ----------------------------------------------------------------------------
`ifndef TIMED_HANDLE_COOLDOWN_TABLE_ASSERT_SVH
`define TIMED_HANDLE_COOLDOWN_TABLE_ASSERT_SVH

// Same-cycle implication under asynchronous active-low reset
`define THCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("thct assertion failed");

// Next-cycle implication under asynchronous active-low reset
`define THCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("thct assertion failed");

`endif

// ----- src/thct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thct_pkg
// Types and constants shared by the timed handle cooldown table.
// ----------------------------------------------------------------------------
package thct_pkg;

	// Default number of table entries
	localparam int unsigned TABLE_DEPTH_DEF = 64;

	// Reset value of the cooldown window in milliseconds
	localparam logic [31:0] WINDOW_RESET = 32'd1200;

	// Configuration register map
	localparam int unsigned PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_COOLDOWN_WINDOW = 2'd0;

	// Operation codes
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_ADD   = 1'b1;

	// Width of the entry count field in a result
	localparam int unsigned HELD_W = 7;

	// One stored table entry
	typedef struct packed {
		logic [31:0] handle;
		logic [31:0] stamp;
	} entry_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_MOVE,
		ST_FINISH
	} state_t;

endpackage

// ----- src/thct_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thct_req_if / thct_rsp_if
// Valid/ready channels carrying table requests and results.
// ----------------------------------------------------------------------------
interface thct_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] handle;
	logic [31:0] now_time;

	modport source (output valid, output operation, output handle, output now_time,
		input ready);
	modport sink (input valid, input operation, input handle, input now_time,
		output ready);
endinterface

interface thct_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [thct_pkg::HELD_W-1:0] entries_held;

	modport source (output valid, output hit, output entries_held, input ready);
	modport sink (input valid, input hit, input entries_held, output ready);
endinterface

// ----- src/timed_handle_cooldown_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_handle_cooldown_table
// Table of recent handles with timestamps, checked and cleaned one entry at a
// time by a small sequencer around an entry memory with one write and one read port.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per item: operation (check or add), handle and
//   now_time. rsp returns one transaction per item: hit and entries_held.
//   The APB port holds cooldown_window at byte address 0; write it only while
//   the block is idle.
// Sequencing:
//   An add is written into the table when it is accepted and then goes
//   straight to finish. A check compares the slots one at a time and ends on
//   a hit; a refilled slot is compared again. An expired match is refilled
//   with the last entry, or dropped if it is the last entry. The memory has
//   one read port with a registered output. req.ready is high only while the
//   sequencer is idle, so the next item is taken at the earliest once the
//   previous result is in the result register.
// Reset:
//   arst_n clears the entry count, the sequencer and the result valid flag and
//   loads cooldown_window with 1200. Table contents are not cleared.
// Stalls:
//   A result waits in the output register while rsp.ready is low; the next
//   item is still accepted, and its own result waits until the register frees.
// ----------------------------------------------------------------------------
module timed_handle_cooldown_table #(
	parameter int unsigned TABLE_DEPTH = thct_pkg::TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	thct_req_if.sink                     req,
	thct_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [thct_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

`include "timed_handle_cooldown_table_assert.svh"

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	thct_pkg::state_t state_q, state_d;

	thct_pkg::entry_t mem_q [TABLE_DEPTH];
	thct_pkg::entry_t rd_q;

	logic [31:0]   window_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [31:0]   key_q;
	logic [31:0]   now_q;
	logic          hit_q;
	logic          rsp_valid_q;
	logic          rsp_hit_q;
	logic [CW-1:0] rsp_count_q;

	logic             req_fire;
	logic             room;
	logic [CW-1:0]    last_w;
	logic             pos_in;
	logic             match;
	logic             live;
	logic             last_is_pos;
	logic [31:0]      age;
	logic [AW-1:0]    rd_addr;
	logic             mem_we;
	logic [AW-1:0]    wr_addr;
	thct_pkg::entry_t wr_data;
	logic             cnt_inc;
	logic             cnt_dec;
	logic             pos_clr;
	logic             pos_inc;
	logic             hit_set;
	logic             fin_load;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == thct_pkg::ADDR_COOLDOWN_WINDOW) ? window_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= thct_pkg::WINDOW_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr == thct_pkg::ADDR_COOLDOWN_WINDOW) begin
			window_q <= pwdata;
		end
	end

	// Shared compare datapath
	assign req_fire    = req.valid && req.ready;
	assign room        = count_q < DEPTH_C;
	assign last_w      = count_q - 1'b1;
	assign pos_in      = pos_q < count_q;
	assign age         = now_q - rd_q.stamp;
	assign match       = rd_q.handle == key_q;
	assign live        = age < window_q;
	assign last_is_pos = last_w == pos_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			thct_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = (req.operation == thct_pkg::OP_ADD) ? thct_pkg::ST_FINISH
						: thct_pkg::ST_SCAN;
				end
			end
			thct_pkg::ST_SCAN: begin
				state_d = pos_in ? thct_pkg::ST_CMP : thct_pkg::ST_FINISH;
			end
			thct_pkg::ST_CMP: begin
				priority if (!match) begin
					state_d = thct_pkg::ST_SCAN;
				end else if (live) begin
					state_d = thct_pkg::ST_FINISH;
				end else if (last_is_pos) begin
					state_d = thct_pkg::ST_SCAN;
				end else begin
					state_d = thct_pkg::ST_MOVE;
				end
			end
			thct_pkg::ST_MOVE: begin
				state_d = thct_pkg::ST_SCAN;
			end
			thct_pkg::ST_FINISH: begin
				if (fin_load) begin
					state_d = thct_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = thct_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs
	always_comb begin
		req.ready = 1'b0;
		rd_addr   = pos_q[AW-1:0];
		mem_we    = 1'b0;
		wr_addr   = pos_q[AW-1:0];
		wr_data   = rd_q;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		pos_clr   = 1'b0;
		pos_inc   = 1'b0;
		hit_set   = 1'b0;
		fin_load  = 1'b0;
		unique case (state_q)
			thct_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				pos_clr   = 1'b1;
				wr_addr   = room ? count_q[AW-1:0] : '0;
				wr_data   = '{handle: req.handle, stamp: req.now_time};
				if (req_fire && req.operation == thct_pkg::OP_ADD) begin
					mem_we  = 1'b1;
					cnt_inc = room;
				end
			end
			thct_pkg::ST_SCAN: begin
				rd_addr = pos_q[AW-1:0];
			end
			thct_pkg::ST_CMP: begin
				// Fetch the last entry in case this slot must be refilled
				rd_addr = last_w[AW-1:0];
				priority if (!match) begin
					pos_inc = 1'b1;
				end else if (live) begin
					hit_set = 1'b1;
				end else if (last_is_pos) begin
					cnt_dec = 1'b1;
				end
			end
			thct_pkg::ST_MOVE: begin
				// Move the last entry into the expired slot
				mem_we  = 1'b1;
				cnt_dec = 1'b1;
			end
			thct_pkg::ST_FINISH: begin
				fin_load = !rsp_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thct_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cnt_dec) begin
				count_q <= last_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			key_q <= req.handle;
			now_q <= req.now_time;
			hit_q <= 1'b0;
		end else if (hit_set) begin
			hit_q <= 1'b1;
		end
		if (pos_clr) begin
			pos_q <= '0;
		end else if (pos_inc) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			rsp_hit_q   <= hit_q;
			rsp_count_q <= count_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = rsp_hit_q;
	assign rsp.entries_held = thct_pkg::HELD_W'(rsp_count_q);

	// Assertions
	`THCT_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH_C)
	`THCT_ASSERT_NEXT(a_add_grows, clk, arst_n,
		req_fire && req.operation == thct_pkg::OP_ADD && room,
		count_q == $past(count_q) + 1'b1)
	`THCT_ASSERT_NEXT(a_scan_no_grow, clk, arst_n,
		state_q != thct_pkg::ST_IDLE, count_q <= $past(count_q))
	`THCT_ASSERT_IMPL(a_finish_wait, clk, arst_n,
		state_q == thct_pkg::ST_FINISH && rsp_valid_q && !rsp.ready, !fin_load)

endmodule

// ----- bench/thct_result_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thct_result_monitor
// Watches the request, result and APB channels of the cooldown table. Keeps a
// shadow copy of the table and window, predicts hit and entry count for every
// accepted request and compares each accepted result in order.
// ----------------------------------------------------------------------------
module thct_result_monitor #(
	parameter int unsigned DEPTH = thct_pkg::TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	thct_req_if                          req,
	thct_rsp_if                          rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [thct_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output int                           mismatches,
	output int                           awaited
);

	typedef struct packed {
		logic                        hit;
		logic [thct_pkg::HELD_W-1:0] held;
	} outcome_t;

	// Shadow table state
	thct_pkg::entry_t shadow_entry [DEPTH];
	int unsigned      shadow_count;
	logic [31:0]      shadow_window;

	// Outcomes of accepted requests, oldest first
	outcome_t awaited_outcomes [$];

	// Apply one request to the shadow table and return its outcome
	function automatic outcome_t predict_outcome(input logic op, input logic [31:0] key,
		input logic [31:0] now);
		outcome_t    res;
		int unsigned slot;
		logic [31:0] age;
		logic        found;
		found = 1'b0;
		slot = 0;
		if (op == thct_pkg::OP_CHECK) begin
			// Scan up; an expired match is replaced by the last entry and rechecked
			while (!found && slot < shadow_count) begin
				if (shadow_entry[slot].handle == key) begin
					age = now - shadow_entry[slot].stamp;
					if (age < shadow_window) begin
						found = 1'b1;
					end else begin
						shadow_entry[slot] = shadow_entry[shadow_count - 1];
						shadow_count--;
					end
				end else begin
					slot++;
				end
			end
		end else if (shadow_count < DEPTH) begin
			shadow_entry[shadow_count] = '{handle: key, stamp: now};
			shadow_count++;
		end else begin
			// Full table: overwrite the first entry
			shadow_entry[0] = '{handle: key, stamp: now};
		end
		res.hit = found;
		res.held = shadow_count[thct_pkg::HELD_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want_v,
		input logic [31:0] got_v);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
	endtask

	initial begin
		mismatches = 0;
		awaited = 0;
		shadow_count = 0;
		shadow_window = thct_pkg::WINDOW_RESET;
	end

	// Retire results, predict new requests, track register writes
	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			shadow_count = 0;
			shadow_window = thct_pkg::WINDOW_RESET;
			awaited_outcomes.delete();
			mismatches = 0;
			awaited = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_outcomes.size() == 0) begin
					report_mismatch("unexpected result", 0, 1);
				end else begin
					want = awaited_outcomes.pop_front();
					if (rsp.hit !== want.hit)
						report_mismatch("hit", want.hit, rsp.hit);
					if (rsp.entries_held !== want.held)
						report_mismatch("entries_held", want.held, rsp.entries_held);
				end
			end
			if (req.valid && req.ready)
				awaited_outcomes.push_back(predict_outcome(req.operation, req.handle,
					req.now_time));
			if (psel && penable && pwrite && pready
					&& paddr == thct_pkg::ADDR_COOLDOWN_WINDOW)
				shadow_window = pwdata;
			awaited = awaited_outcomes.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the cooldown table with a directed opening and several randomized
// phases under different cooldown windows, with random gaps on both channels
// and long result stalls. The monitor predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 400;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 160;
	localparam int LONG_STALL   = 900;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [thct_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	int mon_mismatches;
	int mon_awaited;
	int cycle_count;
	int send_calm;

	thct_req_if req_ch ();
	thct_rsp_if rsp_ch ();

	timed_handle_cooldown_table uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	thct_result_monitor mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mon_mismatches),
		.awaited    (mon_awaited)
	);

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Draw a wait in cycles; now and then start a stretch with no waiting
	function automatic int draw_wait(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm_left = $urandom_range(8, 40);
		return $urandom_range(0, 18);
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic send_item(input logic op, input logic [31:0] key, input logic [31:0] at_ms);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.handle    <= key;
		req_ch.now_time  <= at_ms;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every result is back
	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (mon_awaited != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic apb_write(input logic [thct_pkg::PADDR_W-1:0] addr,
		input logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Result side: random stalls, plus two long hold-offs to back up the block
	initial begin : rsp_side
		int stall;
		int taken;
		int calm;
		taken = 0;
		calm = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait(calm);
			if (taken == 150 || taken == 700)
				stall = LONG_STALL;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken++;
			@(negedge clk);
		end
	end

	// Request side and verdict
	initial begin : stimulus
		logic [31:0] phase_window [PHASES];
		logic [31:0] pool [24];
		logic [31:0] clock_ms;
		logic [31:0] key;
		logic        op;
		int          add_pct;
		int          pool_size;
		int          pick;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = thct_pkg::OP_CHECK;
		req_ch.handle    = '0;
		req_ch.now_time  = '0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = thct_pkg::ADDR_COOLDOWN_WINDOW;
		pwdata           = '0;
		send_calm        = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening under the reset window
		send_item(thct_pkg::OP_CHECK, 32'h0000_0000, 32'd0);        // empty table
		send_item(thct_pkg::OP_ADD,   32'h0000_0000, 32'd0);
		send_item(thct_pkg::OP_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(thct_pkg::OP_CHECK, 32'h0000_0000, 32'd1199);     // one below the window
		send_item(thct_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd1198);     // age across the wrap
		send_item(thct_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd1199);     // expired in the last slot
		send_item(thct_pkg::OP_CHECK, 32'h0000_0000, 32'd1200);     // exactly at the window
		send_item(thct_pkg::OP_ADD,   32'h5A5A_5A5A, 32'd10);
		send_item(thct_pkg::OP_ADD,   32'hA5A5_A5A5, 32'd10);
		send_item(thct_pkg::OP_ADD,   32'h5A5A_5A5A, 32'd2000);
		send_item(thct_pkg::OP_CHECK, 32'h5A5A_5A5A, 32'd2100);     // expire, refill, recheck
		send_item(thct_pkg::OP_ADD,   32'h1234_5678, 32'd3000);
		send_item(thct_pkg::OP_CHECK, 32'h1234_5678, 32'd2999);     // stamp later than now
		send_item(thct_pkg::OP_CHECK, 32'hA5A5_A5A5, 32'd2200);
		send_item(thct_pkg::OP_ADD,   32'h5A5A_5A5A, 32'hFFFF_FF00);
		send_item(thct_pkg::OP_CHECK, 32'h5A5A_5A5A, 32'h0000_0100);
		send_item(thct_pkg::OP_ADD,   32'hFFFF_FFFF, 32'h0000_0000);
		send_item(thct_pkg::OP_CHECK, 32'h0000_0001, 32'h8000_0000); // miss, non-empty table
		drain_requests();

		// Random phases, each under its own window
		phase_window = '{32'd1500, 32'd0, 32'hFFFF_FFFF, 32'd1, thct_pkg::WINDOW_RESET,
			32'd0, 32'd0, 32'd1500};
		phase_window[5] = $urandom;
		phase_window[6] = $urandom_range(50, 5000);
		clock_ms = $urandom;
		for (int ph = 0; ph < PHASES; ph++) begin
			apb_write(thct_pkg::ADDR_COOLDOWN_WINDOW, phase_window[ph]);
			repeat (2) @(negedge clk);
			// The all-ones window phase leans on adds to fill the table
			add_pct = (ph == 2) ? 75 : $urandom_range(30, 60);
			pool_size = $urandom_range(3, 24);
			for (int i = 0; i < 24; i++)
				pool[i] = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(0, 99) < add_pct) ? thct_pkg::OP_ADD
					: thct_pkg::OP_CHECK;
				key = ($urandom_range(0, 4) == 0) ? $urandom
					: pool[$urandom_range(0, pool_size - 1)];
				// Advance time: mostly small steps, some jumps, some steps back
				pick = $urandom_range(0, 99);
				if (pick < 15)
					clock_ms = clock_ms;
				else if (pick < 80)
					clock_ms = clock_ms + $urandom_range(1, 300);
				else if (pick < 92)
					clock_ms = clock_ms + $urandom_range(300, 4000);
				else if (pick < 96)
					clock_ms = $urandom;
				else
					clock_ms = clock_ms - $urandom_range(1, 600);
				send_item(op, key, clock_ms);
			end
			drain_requests();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mon_mismatches == 0 && mon_awaited == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/thct_pkg.sv
src/thct_if.sv
src/timed_handle_cooldown_table.sv
bench/thct_result_monitor.sv
bench/tb_top.sv
